FILE: hw/rtl/cfs_pkg.sv
// cfs_pkg: shared widths, command and status codes and register map of the
// circular fifo with search. No dependencies.
package cfs_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CapW    = 5;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned PDataW  = 32;

  // capacity after reset
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // register map, word index taken from paddr[AddrW-1:2]
  localparam logic [AddrW-1:2] RegCapacity = 1'b0;

  typedef enum logic [CmdW-1:0] {
    CmdEnqueue = 3'd0,
    CmdDequeue = 3'd1,
    CmdPeek    = 3'd2,
    CmdSearch  = 3'd3,
    CmdClear   = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatOk       = 2'd0,
    StatFull     = 2'd1,
    StatEmpty    = 2'd2,
    StatNotFound = 2'd3
  } status_e;

endpackage

FILE: hw/rtl/cfs_if.sv
// cfs_if: valid/ready channel interfaces of the circular fifo with search,
// command channel and result channel. Depends on cfs_pkg.
interface cfs_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [cfs_pkg::CmdW-1:0]            cmd;
  logic signed [cfs_pkg::DataW-1:0]    value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cfs_res_if;
  logic                                valid;
  logic                                ready;
  logic [cfs_pkg::StatusW-1:0]         status;
  logic signed [cfs_pkg::DataW-1:0]    data;
  logic [cfs_pkg::SlotW-1:0]           slot;
  logic [cfs_pkg::CntW-1:0]            count;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, output status, output data, output slot, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data, input slot, input count,
                  input is_empty, input is_full, output ready);
endinterface

FILE: hw/rtl/circular_fifo_with_search_top.sv
// circular_fifo_with_search_top: ring-buffer fifo of signed words with a linear
// search walked one slot per cycle over a store with a single read port.
// Depends on cfs_pkg and the cfs_cmd_if / cfs_res_if interfaces.
//
//   channel   dir  transfer when          payload
//   cmd_i     in   valid & ready          cmd, value
//   res_o     out  valid & ready          status, data, slot, count, is_empty, is_full
//   apb       in   psel&penable&pwrite    capacity at word 0 (writing it clears the queue)
//
// flow: enqueue, clear, unused codes and dequeue/peek on an empty queue answer
//   straight from idle; dequeue and peek pass through the fetch state (registered
//   store read); a search steps the scan state over at most the occupancy, one
//   compare per cycle through the store's single read port
// reset: pointers and occupancy clear, capacity returns to 16, no clearing pass
// stalls: the result sits in an output register; the next command is taken while
//   idle, in the cycle that register drains or once it is empty
module circular_fifo_with_search_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cfs_cmd_if.sink                      cmd_i,
  cfs_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfs_pkg::AddrW-1:0]    paddr,
  input  logic [cfs_pkg::PDataW-1:0]   pwdata,
  output logic [cfs_pkg::PDataW-1:0]   prdata,
  output logic                         pready
);

  // the 5-bit capacity register never puts more than 31 slots in use
  localparam int unsigned MemD   = (DEPTH < 31) ? DEPTH : 31;
  localparam int unsigned PtrW   = $clog2(MemD);
  localparam int unsigned CapMax = MemD;

  typedef enum logic [2:0] {
    SIdle  = 3'b001,
    SFetch = 3'b010,
    SScan  = 3'b100
  } state_e;

  // next pointer, wrapping at the effective capacity
  function automatic logic [PtrW-1:0] wrap_next(input logic [PtrW-1:0] p,
                                                input logic [cfs_pkg::CapW-1:0] cap);
    logic [cfs_pkg::CapW:0] nxt;
    nxt = (cfs_pkg::CapW+1)'(p) + 1'b1;
    return (nxt >= {1'b0, cap}) ? '0 : PtrW'(nxt);
  endfunction

  state_e                             state_q, state_d;
  logic [PtrW-1:0]                    head_q, head_d;
  logic [PtrW-1:0]                    tail_q, tail_d;
  logic [cfs_pkg::CntW-1:0]           occ_q, occ_d;
  logic [cfs_pkg::CapW-1:0]           capacity_q, capacity_d;
  logic [PtrW-1:0]                    scan_idx_q, scan_idx_d;
  logic [cfs_pkg::CntW-1:0]           scan_left_q, scan_left_d;
  logic                               peek_q, peek_d;
  logic signed [cfs_pkg::DataW-1:0]   value_q, value_d;

  logic signed [cfs_pkg::DataW-1:0]   mem [MemD];
  logic signed [cfs_pkg::DataW-1:0]   rd_data_q;
  logic [PtrW-1:0]                    rd_addr;
  logic                               wr_en;

  logic                               res_valid_q, res_valid_d;
  logic [cfs_pkg::StatusW-1:0]        res_status_q, res_status_d;
  logic signed [cfs_pkg::DataW-1:0]   res_data_q, res_data_d;
  logic [cfs_pkg::SlotW-1:0]          res_slot_q, res_slot_d;
  logic [cfs_pkg::CntW-1:0]           res_count_q, res_count_d;
  logic                               res_empty_q, res_empty_d;
  logic                               res_full_q, res_full_d;

  logic [cfs_pkg::CapW-1:0]           cap_eff;
  logic                               cmd_xfer;
  logic                               cfg_we;
  logic                               produce;
  cfs_pkg::status_e                   stat;
  logic signed [cfs_pkg::DataW-1:0]   r_data;
  logic [cfs_pkg::SlotW-1:0]          r_slot;

  // apb: always ready, capacity at word 0
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite
                  && (paddr[cfs_pkg::AddrW-1:2] == cfs_pkg::RegCapacity);
  assign prdata = (paddr[cfs_pkg::AddrW-1:2] == cfs_pkg::RegCapacity)
                  ? cfs_pkg::PDataW'(capacity_q) : '0;

  // zero acts as one, anything above the built depth acts as the depth
  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = cfs_pkg::CapW'(1);
    end else if (capacity_q > cfs_pkg::CapW'(CapMax)) begin
      cap_eff = cfs_pkg::CapW'(CapMax);
    end else begin
      cap_eff = capacity_q;
    end
  end

  // take a command only when the result register is free or drains now
  assign cmd_i.ready = (state_q == SIdle) && (!res_valid_q || res_o.ready);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  // store read address: oldest slot for a fresh command, next slot while scanning
  assign rd_addr = (state_q == SScan) ? wrap_next(scan_idx_q, cap_eff) : head_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    capacity_d  = capacity_q;
    scan_idx_d  = scan_idx_q;
    scan_left_d = scan_left_q;
    peek_d      = peek_q;
    value_d     = value_q;
    wr_en       = 1'b0;
    produce     = 1'b0;
    stat        = cfs_pkg::StatOk;
    r_data      = '0;
    r_slot      = '0;

    case (state_q)
      SIdle: begin
        if (cmd_xfer) begin
          value_d = cmd_i.value;
          case (cmd_i.cmd)
            cfs_pkg::CmdEnqueue: begin
              produce = 1'b1;
              if (occ_q >= cfs_pkg::CntW'(cap_eff)) begin
                stat = cfs_pkg::StatFull;
              end else begin
                wr_en  = 1'b1;
                tail_d = wrap_next(tail_q, cap_eff);
                occ_d  = occ_q + 1'b1;
              end
            end
            cfs_pkg::CmdDequeue, cfs_pkg::CmdPeek: begin
              if (occ_q == '0) begin
                produce = 1'b1;
                stat    = cfs_pkg::StatEmpty;
              end else begin
                // head slot is read at this edge; the fetch state then returns it
                peek_d  = (cmd_i.cmd == cfs_pkg::CmdPeek);
                state_d = SFetch;
              end
            end
            cfs_pkg::CmdSearch: begin
              if (occ_q == '0) begin
                produce = 1'b1;
                stat    = cfs_pkg::StatNotFound;
              end else begin
                scan_idx_d  = head_q;
                scan_left_d = occ_q;
                state_d     = SScan;
              end
            end
            cfs_pkg::CmdClear: begin
              produce = 1'b1;
              head_d  = '0;
              tail_d  = '0;
              occ_d   = '0;
            end
            default: begin
              // unused codes do nothing
              produce = 1'b1;
            end
          endcase
        end
      end
      SFetch: begin
        produce = 1'b1;
        r_data  = rd_data_q;
        if (!peek_q) begin
          head_d = wrap_next(head_q, cap_eff);
          occ_d  = occ_q - 1'b1;
        end
        state_d = SIdle;
      end
      SScan: begin
        // rd_data_q holds the slot at scan_idx_q
        if (rd_data_q == value_q) begin
          produce = 1'b1;
          r_slot  = cfs_pkg::SlotW'(scan_idx_q);
          state_d = SIdle;
        end else if (scan_left_q == cfs_pkg::CntW'(1)) begin
          produce = 1'b1;
          stat    = cfs_pkg::StatNotFound;
          state_d = SIdle;
        end else begin
          scan_idx_d  = rd_addr;
          scan_left_d = scan_left_q - 1'b1;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // capacity write clears the queue; the user must issue it only while idle, the block does not enforce this
    if (cfg_we) begin
      capacity_d = pwdata[cfs_pkg::CapW-1:0];
      head_d     = '0;
      tail_d     = '0;
      occ_d      = '0;
    end
  end

  // result register
  always_comb begin
    res_valid_d  = res_valid_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_slot_d   = res_slot_q;
    res_count_d  = res_count_q;
    res_empty_d  = res_empty_q;
    res_full_d   = res_full_q;
    if (produce) begin
      res_valid_d  = 1'b1;
      res_status_d = stat;
      res_data_d   = r_data;
      res_slot_d   = r_slot;
      res_count_d  = occ_d;
      res_empty_d  = (occ_d == '0);
      res_full_d   = (occ_d >= cfs_pkg::CntW'(cap_eff));
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.status   = res_status_q;
  assign res_o.data     = res_data_q;
  assign res_o.slot     = res_slot_q;
  assign res_o.count    = res_count_q;
  assign res_o.is_empty = res_empty_q;
  assign res_o.is_full  = res_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      capacity_q  <= cfs_pkg::CapReset;
      scan_idx_q  <= '0;
      scan_left_q <= '0;
      peek_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      capacity_q  <= capacity_d;
      scan_idx_q  <= scan_idx_d;
      scan_left_q <= scan_left_d;
      peek_q      <= peek_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_slot_q   <= res_slot_d;
    res_count_q  <= res_count_d;
    res_empty_q  <= res_empty_d;
    res_full_q   <= res_full_d;
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= cmd_i.value;
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule

FILE: tb/sv/cfs_tb_pkg.sv
// cfs_tb_pkg: expected-result tracking for the circular fifo with search test,
// a shadow copy of the queue that predicts and checks every result.
// Depends on cfs_pkg.
package cfs_tb_pkg;
  import cfs_pkg::*;

  localparam int unsigned ShadowDepth = 16;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  data;
    logic [SlotW-1:0]         slot;
    logic [CntW-1:0]          count;
    logic                     is_empty;
    logic                     is_full;
  } fifo_result_t;

  class fifo_shadow;
    logic signed [DataW-1:0] words [ShadowDepth];
    int unsigned             head;
    int unsigned             tail;
    int unsigned             occupancy;
    logic [CapW-1:0]         capacity;
    fifo_result_t            expected_q [$];
    int unsigned             mismatches;

    function new();
      capacity   = CapReset;
      mismatches = 0;
      empty_queue();
    endfunction

    function void empty_queue();
      head      = 0;
      tail      = 0;
      occupancy = 0;
    endfunction

    // writing the register also empties the queue
    function void set_capacity(logic [CapW-1:0] value);
      capacity = value;
      empty_queue();
    endfunction

    // zero acts as one, anything above the store size as the store size
    function int unsigned usable_slots();
      if (capacity == 0) return 1;
      if (capacity > ShadowDepth) return ShadowDepth;
      return capacity;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= usable_slots()) ? 0 : p + 1;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    // apply one accepted command and queue the result it must produce
    function void take_command(logic [CmdW-1:0] cmd, logic signed [DataW-1:0] value);
      fifo_result_t res;
      int unsigned  idx;
      int unsigned  cap;
      cap = usable_slots();
      res = '{status: StatOk, data: '0, slot: '0, count: '0, is_empty: 1'b0, is_full: 1'b0};
      case (cmd)
        CmdEnqueue: begin
          if (occupancy >= cap) begin
            res.status = StatFull;
          end else begin
            words[tail] = value;
            tail = next_slot(tail);
            occupancy++;
          end
        end
        CmdDequeue: begin
          if (occupancy == 0) begin
            res.status = StatEmpty;
          end else begin
            res.data = words[head];
            head = next_slot(head);
            occupancy--;
          end
        end
        CmdPeek: begin
          if (occupancy == 0) res.status = StatEmpty;
          else res.data = words[head];
        end
        CmdSearch: begin
          res.status = StatNotFound;
          idx = head;
          for (int unsigned i = 0; i < occupancy; i++) begin
            if (words[idx] == value) begin
              res.status = StatOk;
              res.slot   = idx[SlotW-1:0];
              break;
            end
            idx = next_slot(idx);
          end
        end
        CmdClear: begin
          empty_queue();
        end
        default: begin
        end
      endcase
      res.count    = occupancy[CntW-1:0];
      res.is_empty = (occupancy == 0);
      res.is_full  = (occupancy >= cap);
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(fifo_result_t got);
      fifo_result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status)
        report_mismatch($sformatf("status exp %0d got %0d", exp.status, got.status));
      if (got.data !== exp.data)
        report_mismatch($sformatf("data exp %08h got %08h", exp.data, got.data));
      if (got.slot !== exp.slot)
        report_mismatch($sformatf("slot exp %0d got %0d", exp.slot, got.slot));
      if (got.count !== exp.count)
        report_mismatch($sformatf("count exp %0d got %0d", exp.count, got.count));
      if (got.is_empty !== exp.is_empty)
        report_mismatch($sformatf("is_empty exp %0b got %0b", exp.is_empty, got.is_empty));
      if (got.is_full !== exp.is_full)
        report_mismatch($sformatf("is_full exp %0b got %0b", exp.is_full, got.is_full));
    endtask
  endclass

endpackage

FILE: tb/sv/circular_fifo_with_search_top_test.sv
// circular_fifo_with_search_top_test: drives commands and capacity writes into
// the circular fifo with search and checks every result against a shadow queue.
// Depends on cfs_pkg, cfs_tb_pkg and the cfs_cmd_if / cfs_res_if interfaces.
module circular_fifo_with_search_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfs_pkg::*;
  import cfs_tb_pkg::*;

  // generous bound: a search may walk every occupied slot and both sides may idle hard
  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned ResetCycles    = 8;
  localparam int unsigned PhaseItems     = 150;
  localparam int unsigned NumPhases      = 8;
  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned SettleCycles   = 4;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  cfs_cmd_if cmd_if ();
  cfs_res_if res_if ();

  circular_fifo_with_search_top #(
    .DEPTH (ShadowDepth)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fifo_shadow shadow = new();

  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;   // chance per cycle that the sender holds back
  int unsigned recv_stall_pct = 0;  // chance per cycle that ready is low
  logic        pressure_req  = 1'b0;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit, ends the run if the block stops responding
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request so that the
  // output register stays full and the command side backs up
  initial begin
    logic pressure_done;
    pressure_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_req && !pressure_done) begin
        repeat (HoldOffCycles) begin
          res_if.ready <= 1'b0;
          @(posedge clk_i);
        end
        pressure_done = 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // observe transfers on both channels; check first so that a result with
  // nothing outstanding is never matched against a command from this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        shadow.check_result('{status: status_e'(res_if.status), data: res_if.data,
                              slot: res_if.slot, count: res_if.count,
                              is_empty: res_if.is_empty, is_full: res_if.is_full});
      end
      if (cmd_if.valid && cmd_if.ready) begin
        shadow.take_command(cmd_if.cmd, cmd_if.value);
      end
    end
  end

  // offer one command and hold it until the transfer, then maybe idle a while
  task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic signed [DataW-1:0] value);
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= cmd;
    cmd_if.value <= value;
    do @(posedge clk_i); while (!cmd_if.ready);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every outstanding result has been taken
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // apb write: setup cycle then access cycle, only while the block is idle
  task automatic write_capacity(input logic [CapW-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegCapacity, 2'b00};
    pwdata  <= PDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow.set_capacity(value);
  endtask

  // mostly values from a small pool so that searches hit, sometimes anything
  function automatic logic signed [DataW-1:0] pick_value();
    logic signed [DataW-1:0] pool [8];
    int unsigned r;
    pool = '{32'sd0, 32'sd1, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff,
             32'sd42, -32'sd42, 32'sh55aa_55aa};
    r = $urandom_range(9);
    if (r < 7) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // random commands, in stretches that lean at random toward filling or draining
  task automatic run_random(input int unsigned n);
    int unsigned enq_weight;
    int unsigned r;
    logic [CmdW-1:0] cmd;
    enq_weight = 40;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 30 == 0) enq_weight = ($urandom_range(1)) ? 45 : 15;
      r = $urandom_range(enq_weight + 51);
      if (r < enq_weight)           cmd = CmdEnqueue;
      else if (r < enq_weight + 25) cmd = CmdDequeue;
      else if (r < enq_weight + 33) cmd = CmdPeek;
      else if (r < enq_weight + 48) cmd = CmdSearch;
      else if (r < enq_weight + 50) cmd = CmdClear;
      else                          cmd = CmdW'($urandom_range(7, 5));
      send_cmd(cmd, pick_value());
    end
  endtask

  initial begin
    logic [CapW-1:0] phase_caps [NumPhases];
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7, 5'd2, 5'd16};

    rst_ni       <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.cmd   <= CmdClear;
    cmd_if.value <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue corners at the reset capacity
    send_cmd(CmdDequeue, 32'sd0);
    send_cmd(CmdPeek, 32'sd0);
    send_cmd(CmdSearch, 32'sd0);
    send_cmd(CmdClear, 32'sd0);
    // unused codes do nothing
    send_cmd(CmdW'(5), -32'sd1);
    send_cmd(CmdW'(6), 32'sh8000_0000);
    send_cmd(CmdW'(7), 32'sh7fff_ffff);
    // extremes of the word
    send_cmd(CmdEnqueue, 32'sh8000_0000);
    send_cmd(CmdEnqueue, 32'sh7fff_ffff);
    send_cmd(CmdEnqueue, 32'sd0);
    send_cmd(CmdEnqueue, -32'sd1);
    send_cmd(CmdPeek, 32'sd0);
    send_cmd(CmdSearch, -32'sd1);
    send_cmd(CmdSearch, 32'sh7fff_ffff);
    send_cmd(CmdSearch, 32'sd12345);
    send_cmd(CmdDequeue, 32'sd0);
    send_cmd(CmdDequeue, 32'sd0);
    send_cmd(CmdSearch, 32'sd0);
    send_cmd(CmdClear, 32'sd0);
    send_cmd(CmdDequeue, 32'sd0);

    // tiny capacity: full queue, enqueue rejected, write pointer wraps
    write_capacity(5'd2);
    send_cmd(CmdEnqueue, 32'sd11);
    send_cmd(CmdEnqueue, 32'sd22);
    send_cmd(CmdEnqueue, 32'sd33);
    send_cmd(CmdDequeue, 32'sd0);
    send_cmd(CmdEnqueue, 32'sd33);
    send_cmd(CmdSearch, 32'sd33);
    send_cmd(CmdSearch, 32'sd22);

    // random phases over capacities and idling patterns
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_capacity(phase_caps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // long result-side hold-off while commands keep coming
      if (p == 0) pressure_req <= 1'b1;
      run_random(PhaseItems);
    end

    drain_results();
    if (shadow.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
